// ===== hw/rtl/isrt_pkg.sv =====
// Shared types and helpers for the insertion sorter.
// No dependencies.
package isrt_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Flip the sign bit so that an unsigned compare gives signed order.
    function automatic logic [DATA_W-1:0] order_key(input data_t v);
        order_key = {~v[DATA_W-1], v[DATA_W-2:0]};
    endfunction

endpackage

// ===== hw/rtl/isrt_ram.sv =====
// Single-port-write, single-port-read store with registered read data.
// Depends on isrt_pkg for the data type.
module isrt_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  isrt_pkg::data_t     wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output isrt_pkg::data_t     rdata
);
    import isrt_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/insertion_sorter.sv =====
// Insertion sorter top level: control sequencer around the sorted store.
// Depends on isrt_pkg and isrt_ram.
//
// Values are accepted one beat at a time (start while busy is low). A value
// is inserted by walking down the store from the top, one read-compare-move
// per cycle through the single store memory: every stored entry strictly
// greater than the value moves up one place before the value is written;
// an empty or full store needs no walk. A beat with end_of_batch set
// closes the batch: the stored values then come out in ascending order, one
// per cycle, each marked by result_valid for exactly one cycle, with
// final_res on the last; the receiver cannot stall this stream. Busy stays
// high until the last store read is issued. Values arriving with the store
// full (MAX_ITEMS entries) are dropped and overflow is raised on every result
// of that batch.
module insertion_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  isrt_pkg::data_t     value,
    input  logic                end_of_batch,
    output logic                result_valid,
    output isrt_pkg::data_t     sorted_value,
    output logic                final_res,
    output logic                overflow
);
    import isrt_pkg::*;

    localparam int unsigned ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    data_t               val_reg;
    logic [ADDR_W-1:0]   pos_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic                drop_reg;
    logic                last_reg;
    logic [ADDR_W-1:0]   emit_idx_reg;
    logic                strobe_reg;
    logic                final_reg;
    logic                ovf_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    data_t               mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    data_t               mem_rdata;

    logic                accept;
    logic                full;
    logic                greater;
    logic                emit_last;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (fill_reg == CNT_W'(MAX_ITEMS));
    assign greater   = order_key(mem_rdata) > order_key(val_reg);
    assign emit_last = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == fill_reg);

    isrt_ram #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re     (mem_re),
        .raddr  (mem_raddr),
        .rdata  (mem_rdata)
    );

    // Store access for the current step.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = val_reg;
        mem_re    = 1'b0;
        mem_raddr = emit_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !full)
                begin
                    if (fill_reg == '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = value;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(fill_reg - CNT_W'(1));
                    end
                end
            end
            ST_SHIFT:
            begin
                mem_we = 1'b1;
                if (greater)
                begin
                    // Move the larger entry up one place, probe the next one down.
                    mem_wdata = mem_rdata;
                    if (pos_reg > ADDR_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_reg - ADDR_W'(2);
                    end
                end
            end
            ST_PLACE:
            begin
                mem_we = 1'b1;
            end
            ST_EMIT:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            val_reg      <= '0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            drop_reg     <= 1'b0;
            last_reg     <= 1'b0;
            emit_idx_reg <= '0;
            strobe_reg   <= 1'b0;
            final_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    emit_idx_reg <= '0;
                    if (accept)
                    begin
                        last_reg <= end_of_batch;
                        if (full)
                        begin
                            // Drop the beat, still close the batch if marked.
                            drop_reg <= 1'b1;
                            if (end_of_batch)
                            begin
                                state_reg <= ST_EMIT;
                            end
                        end
                        else if (fill_reg == '0)
                        begin
                            fill_reg <= CNT_W'(1);
                            if (end_of_batch)
                            begin
                                state_reg <= ST_EMIT;
                            end
                        end
                        else
                        begin
                            val_reg   <= value;
                            pos_reg   <= ADDR_W'(fill_reg);
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    if (greater)
                    begin
                        pos_reg <= pos_reg - ADDR_W'(1);
                        if (pos_reg == ADDR_W'(1))
                        begin
                            state_reg <= ST_PLACE;
                        end
                    end
                    else
                    begin
                        fill_reg  <= fill_reg + CNT_W'(1);
                        state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_PLACE:
                begin
                    fill_reg  <= fill_reg + CNT_W'(1);
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    strobe_reg   <= 1'b1;
                    final_reg    <= emit_last;
                    ovf_reg      <= drop_reg;
                    emit_idx_reg <= emit_idx_reg + ADDR_W'(1);
                    if (emit_last)
                    begin
                        fill_reg  <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = strobe_reg;
    assign sorted_value = mem_rdata;
    assign final_res    = final_reg;
    assign overflow     = ovf_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for insertion_sorter: sends batches of signed values and checks the
// sorted stream against an in-bench insertion model of the store.
// Depends on isrt_pkg and the insertion_sorter RTL.
module testbench;
    import isrt_pkg::*;

    localparam int unsigned CAPACITY    = 64;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RANDOM_BEATS = 30;
    localparam data_t MOST_NEG = 32'h8000_0000;
    localparam data_t MOST_POS = 32'h7FFF_FFFF;

    typedef struct {
        data_t val;
        logic  last;
        logic  dropped;
    } sorted_beat_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t value;
    logic  end_of_batch;
    logic  result_valid;
    data_t sorted_value;
    logic  final_res;
    logic  overflow;

    // shadow copy of the sorted store
    data_t        shadow_store [CAPACITY];
    int unsigned  shadow_fill;
    logic         shadow_dropped;
    sorted_beat_t expected_beats [$];
    int unsigned  mismatches  = 0;
    int unsigned  idle_cycles = 0;
    bit           gaps_on;

    insertion_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .end_of_batch(end_of_batch),
        .result_valid(result_valid),
        .sorted_value(sorted_value),
        .final_res(final_res),
        .overflow(overflow)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Move strictly greater entries up one place so equal values stay in arrival order.
    function automatic void insert_value(data_t v);
        int unsigned pos;
        if (shadow_fill < CAPACITY)
        begin
            pos = shadow_fill;
            while (pos > 0 && shadow_store[pos-1] > v)
            begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = v;
            shadow_fill++;
        end
        else
        begin
            shadow_dropped = 1'b1;
        end
    endfunction

    function automatic void close_batch();
        sorted_beat_t b;
        for (int unsigned k = 0; k < shadow_fill; k++)
        begin
            b.val     = shadow_store[k];
            b.last    = (k + 1 == shadow_fill);
            b.dropped = shadow_dropped;
            expected_beats.push_back(b);
        end
        shadow_fill    = 0;
        shadow_dropped = 1'b0;
    endfunction

    function automatic data_t pick_value();
        data_t v;
        case ($urandom_range(7))
            0: v = MOST_NEG;
            1: v = MOST_POS;
            2: v = '0;
            3: v = -1;
            4, 5: v = data_t'($urandom_range(16)) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Drive one beat at the falling edge and hold it until busy is low at a rising edge.
    task automatic send_value(input data_t v, input logic eob);
        if (gaps_on && $urandom_range(3) == 0)
        begin
            @(negedge clk);
            start        <= 1'b0;
            value        <= $urandom;
            end_of_batch <= 1'($urandom_range(1));
            repeat ($urandom_range(13)) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        value        <= v;
        end_of_batch <= eob;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        insert_value(v);
        if (eob)
        begin
            close_batch();
        end
    endtask

    task automatic send_batch(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_value(pick_value(), i + 1 == count);
        end
    endtask

    task automatic test_single_value();
        send_value(MOST_NEG, 1'b1);
        send_value(MOST_POS, 1'b1);
    endtask

    task automatic test_extremes();
        send_value(MOST_POS, 1'b0);
        send_value(MOST_NEG, 1'b0);
        send_value('0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(MOST_NEG + 1, 1'b1);
    endtask

    task automatic test_orderings();
        // descending input walks every value to the bottom entry
        for (int i = 4; i >= 0; i--)
        begin
            send_value(data_t'(i * 1000 - 2000), i == 0);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_value(data_t'(i - 2), i == 3);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_value(data_t'(-7), i == 3);
        end
    endtask

    task automatic test_capacity();
        // exactly full, then drops with the mark on a dropped value, then more drops
        send_batch(CAPACITY);
        send_batch(CAPACITY + 1);
        send_batch(CAPACITY + 6);
        send_batch(3);
    endtask

    task automatic test_random();
        int unsigned sent;
        int unsigned count;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if ($urandom_range(9) == 0)
            begin
                count = $urandom_range(40, 20);
            end
            else
            begin
                count = $urandom_range(12, 1);
            end
            for (int unsigned i = 0; i < count; i++)
            begin
                // drop idling for the last quarter of the run
                gaps_on = (sent < RANDOM_BEATS * 3 / 4);
                send_value(pick_value(), i + 1 == count);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sorted_beat_t want;
        if (rst_n && result_valid)
        begin
            if (expected_beats.size() == 0)
            begin
                note_failure($sformatf("unexpected beat: value %0d final %b overflow %b",
                                       sorted_value, final_res, overflow));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (sorted_value !== want.val || final_res !== want.last ||
                    overflow !== want.dropped)
                begin
                    note_failure($sformatf(
                        "mismatch: expected value %0d final %b overflow %b, got %0d %b %b",
                        want.val, want.last, want.dropped,
                        sorted_value, final_res, overflow));
                end
            end
        end
    end

    // count cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        start          = 1'b0;
        value          = '0;
        end_of_batch   = 1'b0;
        rst_n          = 1'b0;
        shadow_fill    = 0;
        shadow_dropped = 1'b0;
        gaps_on        = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_value();
        test_extremes();
        test_orderings();
        test_capacity();
        test_random();

        @(negedge clk);
        start <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (CAPACITY + 16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/isrt_pkg.sv
hw/rtl/isrt_ram.sv
hw/rtl/insertion_sorter.sv
dv/testbench.sv
